@@ hw/rtl/route_length_capacity_check_defines.svh @@
// Assertion helpers used by the route checker RTL.
`ifndef ROUTE_LENGTH_CAPACITY_CHECK_DEFINES_SVH
`define ROUTE_LENGTH_CAPACITY_CHECK_DEFINES_SVH

// Same-cycle implication.
`define RLCC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlcc: implication check failed");

// Next-cycle implication.
`define RLCC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlcc: next-cycle check failed");

`endif

@@ hw/rtl/rlcc_pkg.sv @@
package rlcc_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned FRAC_BITS   = 8;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned DEM_W   = 10;
  localparam int unsigned ENTRY_W = 2 * COORD_W + DEM_W;
  localparam int unsigned TBL_AW  = $clog2(TABLE_DEPTH);

  localparam int unsigned CAP_W    = 16;
  localparam int unsigned CAPL_W   = 18;
  localparam int unsigned CAPO_W   = 17;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned TOTAL_W  = 40;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(200);
  localparam logic signed [CAPL_W-1:0] CAP_FLOOR = CAPL_W'(-65535);

  localparam int unsigned SQ_W    = 2 * COORD_W;
  localparam int unsigned SUMSQ_W = SQ_W + 1;
  localparam int unsigned RAD_W   = ((SUMSQ_W + 2 * FRAC_BITS + 1) / 2) * 2;
  localparam int unsigned ROOT_W  = RAD_W / 2;
  localparam int unsigned REM_W   = ROOT_W + 1;
  localparam int unsigned CNT_W   = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_UPDATE,
    ST_TOTAL
  } state_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STOP = 1'b1
  } opcode_t;

  typedef struct packed {
    logic start;
    logic [RAD_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

@@ hw/rtl/rlcc_in_if.sv @@
interface rlcc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [rlcc_pkg::IDX_W-1:0]   customer_index;
  logic [rlcc_pkg::COORD_W-1:0] coord_x;
  logic [rlcc_pkg::COORD_W-1:0] coord_y;
  logic [rlcc_pkg::DEM_W-1:0]   customer_demand;
  logic                         last_stop;

  modport source (output valid, opcode, customer_index, coord_x, coord_y,
                  customer_demand, last_stop, input ready);
  modport sink (input valid, opcode, customer_index, coord_x, coord_y,
                customer_demand, last_stop, output ready);
endinterface

@@ hw/rtl/rlcc_out_if.sv @@
interface rlcc_out_if;
  logic                                valid;
  logic                                ready;
  logic [rlcc_pkg::ACC_W-1:0]          route_length;
  logic signed [rlcc_pkg::CAPO_W-1:0]  capacity_remaining;
  logic                                capacity_overflow;
  logic [rlcc_pkg::TOTAL_W-1:0]        total_length;

  modport source (output valid, route_length, capacity_remaining, capacity_overflow,
                  total_length, input ready);
  modport sink (input valid, route_length, capacity_remaining, capacity_overflow,
                total_length, output ready);
endinterface

@@ hw/rtl/rlcc_ram.sv @@
module rlcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/rlcc_isqrt.sv @@
module rlcc_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  rlcc_pkg::sqrt_req_t req,
  output rlcc_pkg::sqrt_rsp_t rsp
);

  logic [rlcc_pkg::RAD_W-1:0]  rad;
  logic [rlcc_pkg::REM_W-1:0]  rem;
  logic [rlcc_pkg::ROOT_W-1:0] root;
  logic [rlcc_pkg::CNT_W-1:0]  cnt;
  logic                        busy;
  logic                        done;

  logic [rlcc_pkg::REM_W+1:0]  cur;
  logic [rlcc_pkg::REM_W+1:0]  trial;
  logic                        fits;

  assign cur   = {rem, rad[rlcc_pkg::RAD_W-1 -: 2]};
  assign trial = (rlcc_pkg::REM_W + 2)'({root, 2'b01});
  assign fits  = cur >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == rlcc_pkg::CNT_W'(rlcc_pkg::ROOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= fits ? rlcc_pkg::REM_W'(cur - trial) : rlcc_pkg::REM_W'(cur);
      root <= {root[rlcc_pkg::ROOT_W-2:0], fits};
      cnt  <= cnt + 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

@@ hw/rtl/route_length_capacity_check.sv @@
// Load item: accepted while idle; ready stays high for the next item.
// Stop item: read, squaring, the 19-step single square-root unit and an update step lie
// between accept and the next accept, plus a total step that waits for a free output register
// when it closes a route. The first stop of a route skips the squaring and root steps.
// Result appears in an output register; a new item is taken while it waits.
// Synchronous active-high reset clears control and route state; capacity = 200.
`include "route_length_capacity_check_defines.svh"

module route_length_capacity_check (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rlcc_pkg::CAP_W-1:0] cfg_wdata,
  rlcc_in_if.sink                   cmd,
  rlcc_out_if.source                res
);

  rlcc_pkg::state_t state, state_next;

  logic [rlcc_pkg::CAP_W-1:0]          vcap;
  logic                                route_start;
  logic [rlcc_pkg::ACC_W-1:0]          route_acc;
  logic signed [rlcc_pkg::CAPL_W-1:0]  cap_left;
  logic                                ovf;
  logic [rlcc_pkg::TOTAL_W-1:0]        grand_total;
  logic [rlcc_pkg::COORD_W-1:0]        prev_x;
  logic [rlcc_pkg::COORD_W-1:0]        prev_y;

  logic [rlcc_pkg::COORD_W-1:0]        cur_x;
  logic [rlcc_pkg::COORD_W-1:0]        cur_y;
  logic [rlcc_pkg::DEM_W-1:0]          cur_dem;
  logic                                cur_hit;
  logic                                cur_last;
  logic [rlcc_pkg::SQ_W-1:0]           sqx;

  logic                                accept;
  logic                                in_range;
  logic                                ram_we;
  logic [rlcc_pkg::TBL_AW-1:0]         addr;
  logic [rlcc_pkg::ENTRY_W-1:0]        wentry;
  logic [rlcc_pkg::ENTRY_W-1:0]        rentry;
  logic                                out_free;

  rlcc_pkg::sqrt_req_t                 sq_req;
  rlcc_pkg::sqrt_rsp_t                 sq_rsp;

  logic [rlcc_pkg::COORD_W-1:0]        dx;
  logic [rlcc_pkg::COORD_W-1:0]        dy;
  logic [rlcc_pkg::SQ_W-1:0]           sqy;
  logic [rlcc_pkg::SUMSQ_W-1:0]        sumsq;
  logic [rlcc_pkg::ACC_W:0]            acc_sum;
  logic [rlcc_pkg::ACC_W-1:0]          acc_new;
  logic signed [rlcc_pkg::CAPL_W-1:0]  cap_diff;
  logic signed [rlcc_pkg::CAPL_W-1:0]  cap_new;
  logic [rlcc_pkg::TOTAL_W:0]          tot_sum;

  assign accept   = cmd.valid && cmd.ready;
  assign in_range = 32'(cmd.customer_index) < rlcc_pkg::TABLE_DEPTH;
  assign addr     = rlcc_pkg::TBL_AW'(cmd.customer_index);
  assign wentry   = {cmd.customer_demand, cmd.coord_y, cmd.coord_x};
  assign out_free = !res.valid || res.ready;

  rlcc_ram #(
    .WIDTH(rlcc_pkg::ENTRY_W),
    .DEPTH(rlcc_pkg::TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr),
    .wdata(wentry),
    .raddr(addr),
    .rdata(rentry)
  );

  rlcc_isqrt u_isqrt (
    .clk(clk),
    .rst(rst),
    .req(sq_req),
    .rsp(sq_rsp)
  );

  assign dx    = (cur_x > prev_x) ? cur_x - prev_x : prev_x - cur_x;
  assign dy    = (cur_y > prev_y) ? cur_y - prev_y : prev_y - cur_y;
  assign sqy   = rlcc_pkg::SQ_W'(dy) * rlcc_pkg::SQ_W'(dy);
  assign sumsq = {1'b0, sqx} + {1'b0, sqy};

  assign acc_sum  = {1'b0, route_acc} + (rlcc_pkg::ACC_W + 1)'(sq_rsp.root);
  assign acc_new  = acc_sum[rlcc_pkg::ACC_W] ? '1 : acc_sum[rlcc_pkg::ACC_W-1:0];
  assign cap_diff = cap_left - $signed(rlcc_pkg::CAPL_W'(cur_dem));
  assign cap_new  = (cap_diff < rlcc_pkg::CAP_FLOOR) ? rlcc_pkg::CAP_FLOOR : cap_diff;
  assign tot_sum  = {1'b0, grand_total} + (rlcc_pkg::TOTAL_W + 1)'(route_acc);

  always_comb begin
    state_next = state;
    unique case (state)
      rlcc_pkg::ST_IDLE: begin
        if (accept && cmd.opcode == rlcc_pkg::OP_STOP) begin
          state_next = rlcc_pkg::ST_READ;
        end
      end
      rlcc_pkg::ST_READ: begin
        state_next = route_start ? rlcc_pkg::ST_UPDATE : rlcc_pkg::ST_SQX;
      end
      rlcc_pkg::ST_SQX:  state_next = rlcc_pkg::ST_SQY;
      rlcc_pkg::ST_SQY:  state_next = rlcc_pkg::ST_ROOT;
      rlcc_pkg::ST_ROOT: begin
        if (sq_rsp.done) begin
          state_next = rlcc_pkg::ST_UPDATE;
        end
      end
      rlcc_pkg::ST_UPDATE: begin
        state_next = cur_last ? rlcc_pkg::ST_TOTAL : rlcc_pkg::ST_IDLE;
      end
      rlcc_pkg::ST_TOTAL: begin
        if (out_free) begin
          state_next = rlcc_pkg::ST_IDLE;
        end
      end
      default: state_next = rlcc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready       = 1'b0;
    ram_we          = 1'b0;
    sq_req.start    = 1'b0;
    sq_req.radicand = rlcc_pkg::RAD_W'(sumsq) << (2 * rlcc_pkg::FRAC_BITS);
    unique case (state)
      rlcc_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        ram_we    = cmd.valid && cmd.opcode == rlcc_pkg::OP_LOAD && in_range;
      end
      rlcc_pkg::ST_SQY: sq_req.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlcc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcap <= rlcc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      vcap <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_hit  <= in_range;
      cur_last <= cmd.last_stop;
    end
    if (state == rlcc_pkg::ST_READ) begin
      cur_x   <= cur_hit ? rentry[rlcc_pkg::COORD_W-1:0] : '0;
      cur_y   <= cur_hit ? rentry[2*rlcc_pkg::COORD_W-1:rlcc_pkg::COORD_W] : '0;
      cur_dem <= cur_hit ? rentry[rlcc_pkg::ENTRY_W-1:2*rlcc_pkg::COORD_W] : '0;
    end
    if (state == rlcc_pkg::ST_SQX) begin
      sqx <= rlcc_pkg::SQ_W'(dx) * rlcc_pkg::SQ_W'(dx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      route_start <= 1'b1;
      route_acc   <= '0;
      cap_left    <= '0;
      ovf         <= 1'b0;
      grand_total <= '0;
      prev_x      <= '0;
      prev_y      <= '0;
      res.valid   <= 1'b0;
    end else begin
      if (state == rlcc_pkg::ST_UPDATE) begin
        prev_x <= cur_x;
        prev_y <= cur_y;
        route_start <= 1'b0;
        if (route_start) begin
          route_acc <= '0;
          cap_left  <= $signed(rlcc_pkg::CAPL_W'(vcap));
          ovf       <= 1'b0;
        end else begin
          route_acc <= acc_new;
          cap_left  <= cap_new;
          ovf       <= ovf || cap_new < 0;
        end
      end
      if (state == rlcc_pkg::ST_TOTAL && out_free) begin
        grand_total <= tot_sum[rlcc_pkg::TOTAL_W] ? '1 : tot_sum[rlcc_pkg::TOTAL_W-1:0];
        route_start <= 1'b1;
        res.valid   <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rlcc_pkg::ST_TOTAL && out_free) begin
      res.route_length       <= route_acc;
      res.capacity_remaining <= cap_left[rlcc_pkg::CAPO_W-1:0];
      res.capacity_overflow  <= ovf;
      res.total_length       <= tot_sum[rlcc_pkg::TOTAL_W] ? '1
                                : tot_sum[rlcc_pkg::TOTAL_W-1:0];
    end
  end

  `RLCC_ASSERT_IMP(a_root_in_state, clk, rst, sq_rsp.done, state == rlcc_pkg::ST_ROOT)
  `RLCC_ASSERT_NXT(a_stop_reads, clk, rst, accept && cmd.opcode == rlcc_pkg::OP_STOP,
                   state == rlcc_pkg::ST_READ)
  `RLCC_ASSERT_IMP(a_out_from_total, clk, rst, $rose(res.valid),
                   $past(state) == rlcc_pkg::ST_TOTAL)
  `RLCC_ASSERT_IMP(a_cap_floor, clk, rst, 1'b1, cap_left >= rlcc_pkg::CAP_FLOOR)

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [rlcc_pkg::ACC_W-1:0]   length;
    logic [rlcc_pkg::CAPO_W-1:0]  cap;
    logic                         over;
    logic [rlcc_pkg::TOTAL_W-1:0] total;
  } route_summary_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [rlcc_pkg::CAP_W-1:0] cfg_wdata;

  rlcc_in_if  cmd_if();
  rlcc_out_if res_if();

  route_length_capacity_check dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_if),
    .res       (res_if)
  );

  logic [rlcc_pkg::COORD_W-1:0] tbl_x   [rlcc_pkg::TABLE_DEPTH];
  logic [rlcc_pkg::COORD_W-1:0] tbl_y   [rlcc_pkg::TABLE_DEPTH];
  logic [rlcc_pkg::DEM_W-1:0]   tbl_dem [rlcc_pkg::TABLE_DEPTH];
  bit                           tbl_loaded [rlcc_pkg::TABLE_DEPTH];
  int                           loaded_ids[$];

  logic [rlcc_pkg::COORD_W-1:0] last_x;
  logic [rlcc_pkg::COORD_W-1:0] last_y;
  bit                           route_idle;
  longint unsigned              leg_sum;
  int                           cap_left;
  bit                           cap_over;
  longint unsigned              fleet_total;
  logic [rlcc_pkg::CAP_W-1:0]   cap_setting;

  route_summary_t route_summaries[$];
  int  errors;
  int  routes_checked;
  int  items_sent;
  bit  calm;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    res_if.ready <= calm || ($urandom_range(99) >= 19);
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch at route %0d: %s", routes_checked, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    route_summary_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (route_summaries.size() == 0) begin
        note_mismatch("result with no route closed");
      end else begin
        want = route_summaries.pop_front();
        if (res_if.route_length !== want.length)
          note_mismatch($sformatf("route_length %0h, want %0h", res_if.route_length,
                                  want.length));
        if (res_if.capacity_remaining !== want.cap)
          note_mismatch($sformatf("capacity_remaining %0d, want %0d",
                                  res_if.capacity_remaining, $signed(want.cap)));
        if (res_if.capacity_overflow !== want.over)
          note_mismatch($sformatf("capacity_overflow %0b, want %0b",
                                  res_if.capacity_overflow, want.over));
        if (res_if.total_length !== want.total)
          note_mismatch($sformatf("total_length %0h, want %0h", res_if.total_length,
                                  want.total));
      end
      routes_checked++;
    end
  end

  function automatic longint unsigned leg_length(input logic [rlcc_pkg::COORD_W-1:0] ax,
                                                 input logic [rlcc_pkg::COORD_W-1:0] ay,
                                                 input logic [rlcc_pkg::COORD_W-1:0] bx,
                                                 input logic [rlcc_pkg::COORD_W-1:0] by);
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned sq;
    longint unsigned root;
    longint unsigned trial;
    int b;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    sq = (dx * dx + dy * dy) << (2 * rlcc_pkg::FRAC_BITS);
    root = 0;
    for (b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    return root;
  endfunction

  task automatic predict_item(input rlcc_pkg::opcode_t op,
                              input logic [rlcc_pkg::IDX_W-1:0] idx,
                              input logic [rlcc_pkg::COORD_W-1:0] x,
                              input logic [rlcc_pkg::COORD_W-1:0] y,
                              input logic [rlcc_pkg::DEM_W-1:0] dem, input logic last);
    route_summary_t done;
    if (op == rlcc_pkg::OP_LOAD) begin
      tbl_x[idx] = x;
      tbl_y[idx] = y;
      tbl_dem[idx] = dem;
      tbl_loaded[idx] = 1'b1;
    end else begin
      if (route_idle) begin
        route_idle = 1'b0;
        leg_sum = 0;
        cap_left = int'(cap_setting);
        cap_over = 1'b0;
      end else begin
        leg_sum += leg_length(tbl_x[idx], tbl_y[idx], last_x, last_y);
        if (leg_sum > 64'hFFFF_FFFF) leg_sum = 64'hFFFF_FFFF;
        cap_left -= int'(tbl_dem[idx]);
        if (cap_left < -65535) cap_left = -65535;
        if (cap_left < 0) cap_over = 1'b1;
      end
      last_x = tbl_x[idx];
      last_y = tbl_y[idx];
      if (last) begin
        fleet_total += leg_sum;
        if (fleet_total > 64'hFF_FFFF_FFFF) fleet_total = 64'hFF_FFFF_FFFF;
        route_idle = 1'b1;
        done.length = leg_sum[rlcc_pkg::ACC_W-1:0];
        done.cap = cap_left[rlcc_pkg::CAPO_W-1:0];
        done.over = cap_over;
        done.total = fleet_total[rlcc_pkg::TOTAL_W-1:0];
        route_summaries.insert(route_summaries.size(), done);
      end
    end
  endtask

  task automatic send_item(input rlcc_pkg::opcode_t op, input logic [rlcc_pkg::IDX_W-1:0] idx,
                           input logic [rlcc_pkg::COORD_W-1:0] x,
                           input logic [rlcc_pkg::COORD_W-1:0] y,
                           input logic [rlcc_pkg::DEM_W-1:0] dem, input logic last);
    if (!calm && $urandom_range(99) < 19) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.opcode <= op;
    cmd_if.customer_index <= idx;
    cmd_if.coord_x <= x;
    cmd_if.coord_y <= y;
    cmd_if.customer_demand <= dem;
    cmd_if.last_stop <= last;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    items_sent++;
    predict_item(op, idx, x, y, dem, last);
  endtask

  task automatic load_customer(input logic [rlcc_pkg::IDX_W-1:0] idx,
                               input logic [rlcc_pkg::COORD_W-1:0] x,
                               input logic [rlcc_pkg::COORD_W-1:0] y,
                               input logic [rlcc_pkg::DEM_W-1:0] dem);
    if (!tbl_loaded[idx]) loaded_ids.insert(loaded_ids.size(), int'(idx));
    send_item(rlcc_pkg::OP_LOAD, idx, x, y, dem, 1'($urandom));
  endtask

  task automatic visit(input logic [rlcc_pkg::IDX_W-1:0] idx, input logic last);
    send_item(rlcc_pkg::OP_STOP, idx, 10'($urandom), 10'($urandom), 10'($urandom), last);
  endtask

  function automatic logic [9:0] pick_field();
    int roll;
    roll = $urandom_range(99);
    if (roll < 12) return 10'd0;
    if (roll < 24) return 10'h3FF;
    return 10'($urandom);
  endfunction

  // drop valid, wait for every closed route to come back, then let the block go idle
  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (route_summaries.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [rlcc_pkg::CAP_W-1:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_setting = value;
  endtask

  task automatic test_directed();
    load_customer(10'd0, 10'd0, 10'd0, 10'd0);
    load_customer(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
    load_customer(10'd1, 10'h3FF, 10'd0, 10'd512);
    load_customer(10'd2, 10'd0, 10'h3FF, 10'd1);
    load_customer(10'd3, 10'h155, 10'h2AA, 10'h155);
    load_customer(10'd4, 10'h2AA, 10'h155, 10'h2AA);
    visit(10'h3FF, 1'b1);
    visit(10'd0, 1'b0);
    visit(10'h3FF, 1'b1);
    visit(10'd1, 1'b0);
    visit(10'd2, 1'b0);
    visit(10'd0, 1'b0);
    visit(10'd3, 1'b0);
    visit(10'd4, 1'b1);
    visit(10'd3, 1'b0);
    visit(10'd3, 1'b1);
    load_customer(10'd0, 10'd5, 10'd5, 10'd7);
    visit(10'd2, 1'b0);
    visit(10'd0, 1'b0);
    load_customer(10'd2, 10'd900, 10'd17, 10'd300);
    visit(10'd2, 1'b1);
  endtask

  task automatic test_capacity_floor();
    int i;
    set_capacity(16'd0);
    load_customer(10'd10, 10'd0, 10'd0, 10'h3FF);
    load_customer(10'd11, 10'h3FF, 10'h3FF, 10'h3FF);
    for (i = 0; i < 70; i++) visit((i % 2) ? 10'd11 : 10'd10, i == 69);
    set_capacity(16'hFFFF);
    visit(10'd11, 1'b0);
    visit(10'd10, 1'b0);
    visit(10'd3, 1'b1);
  endtask

  // bounce the route between opposite corners for many legs
  task automatic test_long_route();
    int i;
    set_capacity(16'($urandom));
    load_customer(10'd20, 10'd0, 10'd0, 10'd0);
    load_customer(10'd21, 10'h3FF, 10'h3FF, 10'd0);
    for (i = 0; i < 200; i++) visit((i % 2) ? 10'd21 : 10'd20, i == 199);
  endtask

  task automatic run_route(input int stops);
    int i;
    for (i = 0; i < stops; i++) begin
      if ($urandom_range(99) < 10)
        load_customer(10'($urandom), pick_field(), pick_field(), pick_field());
      visit(10'(loaded_ids[$urandom_range(loaded_ids.size() - 1)]), i == stops - 1);
    end
  endtask

  task automatic test_random_routes();
    logic [rlcc_pkg::CAP_W-1:0] caps[5];
    int phase;
    int start;
    caps = '{16'($urandom), 16'd0, 16'hFFFF, rlcc_pkg::CAP_RESET, 16'($urandom_range(3000))};
    for (phase = 0; phase < 5; phase++) begin
      set_capacity(caps[phase]);
      calm = (phase == 3);
      start = items_sent;
      while (items_sent - start < 240) begin
        if (loaded_ids.size() < 4 || $urandom_range(99) < 20) begin
          if ($urandom_range(1))
            load_customer(10'($urandom_range(63)), pick_field(), pick_field(), pick_field());
          else
            load_customer(10'($urandom), pick_field(), pick_field(), pick_field());
        end else begin
          run_route($urandom_range(10, 1));
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cmd_if.valid = 1'b0;
    cmd_if.opcode = rlcc_pkg::OP_LOAD;
    cmd_if.customer_index = '0;
    cmd_if.coord_x = '0;
    cmd_if.coord_y = '0;
    cmd_if.customer_demand = '0;
    cmd_if.last_stop = 1'b0;
    errors = 0;
    routes_checked = 0;
    items_sent = 0;
    calm = 1'b0;
    route_idle = 1'b1;
    last_x = '0;
    last_y = '0;
    leg_sum = 0;
    cap_left = 0;
    cap_over = 1'b0;
    fleet_total = 0;
    cap_setting = rlcc_pkg::CAP_RESET;
    foreach (tbl_loaded[i]) tbl_loaded[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_capacity_floor();
    test_long_route();
    test_random_routes();
    settle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ route_length_capacity_check.f @@
+incdir+hw/rtl
hw/rtl/rlcc_pkg.sv
hw/rtl/rlcc_in_if.sv
hw/rtl/rlcc_out_if.sv
hw/rtl/rlcc_ram.sv
hw/rtl/rlcc_isqrt.sv
hw/rtl/route_length_capacity_check.sv
tb/tb.sv
